[rtl/core/i2cras_pkg.sv]
// ----------------------------------------------------------------------------
// I2C register access sequencer package
// Opcodes, command codes, status codes and the request/result types shared
// by the interfaces, the sequencer core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cras_pkg;

  // Request opcodes.
  localparam logic [2:0] OP_WRITE_TWO = 3'd0;
  localparam logic [2:0] OP_WRITE_ONE = 3'd1;
  localparam logic [2:0] OP_READ_TWO  = 3'd2;
  localparam logic [2:0] OP_EVENT     = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;

  // Controller commands.
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_SINGLE    = 3'd2;
  localparam logic [2:0] CMD_CONT      = 3'd3;
  localparam logic [2:0] CMD_FINISH    = 3'd4;
  localparam logic [2:0] CMD_RX_START  = 3'd5;
  localparam logic [2:0] CMD_RX_FINISH = 3'd6;

  // Completion status.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BUS_ERR = 2'd1;
  localparam logic [1:0] STAT_TIMEOUT = 2'd2;

  localparam int unsigned TIMEOUT_W = 21;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 21'd2000000;

  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] device_address;
    logic [7:0] register_index;
    logic [7:0] first_write_byte;
    logic [7:0] second_write_byte;
    logic       bus_error;
    logic [7:0] received_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [6:0]  target_address;
    logic        read_direction;
    logic        load_address;
    logic [7:0]  transmit_byte;
    logic        transmit_valid;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] read_word;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/i2cras_req_if.sv]
// ----------------------------------------------------------------------------
// I2C register access sequencer request channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cras_req_if;
  logic              valid;
  logic              ready;
  i2cras_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/i2cras_res_if.sv]
// ----------------------------------------------------------------------------
// I2C register access sequencer result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cras_res_if;
  logic              valid;
  logic              ready;
  i2cras_pkg::res_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/i2cras_seq.sv]
// ----------------------------------------------------------------------------
// I2C register access sequencer core
// Holds the transaction state and works out the command for each accepted
// request in one pass of combinational logic.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cras_seq (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 take,
  input  wire i2cras_pkg::req_t                     item,
  input  wire logic [i2cras_pkg::TIMEOUT_W-1:0]     timeout,
  output i2cras_pkg::res_t                          result
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_WR_FIRST  = 3'd1;
  localparam logic [2:0] ST_WR_SECOND = 3'd2;
  localparam logic [2:0] ST_WR_ONLY   = 3'd3;
  localparam logic [2:0] ST_WR_END    = 3'd4;
  localparam logic [2:0] ST_RD_REG    = 3'd5;
  localparam logic [2:0] ST_RD_FIRST  = 3'd6;
  localparam logic [2:0] ST_RD_SECOND = 3'd7;

  logic [2:0]                          state, state_next;
  logic [6:0]                          saved_device, saved_device_next;
  logic [15:0]                         pending, pending_next;
  logic [7:0]                          first_rd, first_rd_next;
  logic [i2cras_pkg::TIMEOUT_W-1:0]    ticks_left, ticks_left_next;

  // Next state and result for the request at the input.
  always_comb begin
    state_next        = state;
    saved_device_next = saved_device;
    pending_next      = pending;
    first_rd_next     = first_rd;
    ticks_left_next   = ticks_left;
    result            = '0;
    unique case (item.opcode) inside
      i2cras_pkg::OP_WRITE_TWO, i2cras_pkg::OP_WRITE_ONE, i2cras_pkg::OP_READ_TWO: begin
        saved_device_next       = item.device_address;
        pending_next            = {item.first_write_byte, item.second_write_byte};
        ticks_left_next         = timeout;
        result.target_address   = item.device_address;
        result.load_address     = 1'b1;
        result.transmit_byte    = item.register_index;
        result.transmit_valid   = 1'b1;
        if (item.opcode == i2cras_pkg::OP_WRITE_TWO) begin
          state_next     = ST_WR_FIRST;
          result.command = i2cras_pkg::CMD_START;
        end else if (item.opcode == i2cras_pkg::OP_WRITE_ONE) begin
          state_next     = ST_WR_ONLY;
          result.command = i2cras_pkg::CMD_START;
        end else begin
          state_next     = ST_RD_REG;
          result.command = i2cras_pkg::CMD_SINGLE;
        end
      end
      i2cras_pkg::OP_EVENT: begin
        if (state != ST_IDLE) begin
          if (item.bus_error) begin
            state_next      = ST_IDLE;
            result.done_res = 1'b1;
            result.status   = i2cras_pkg::STAT_BUS_ERR;
          end else begin
            unique case (state)
              ST_WR_FIRST: begin
                result.command        = i2cras_pkg::CMD_CONT;
                result.transmit_byte  = pending[15:8];
                result.transmit_valid = 1'b1;
                state_next            = ST_WR_SECOND;
              end
              ST_WR_SECOND: begin
                result.command        = i2cras_pkg::CMD_FINISH;
                result.transmit_byte  = pending[7:0];
                result.transmit_valid = 1'b1;
                state_next            = ST_WR_END;
              end
              ST_WR_ONLY: begin
                result.command        = i2cras_pkg::CMD_FINISH;
                result.transmit_byte  = pending[15:8];
                result.transmit_valid = 1'b1;
                state_next            = ST_WR_END;
              end
              ST_WR_END: begin
                state_next      = ST_IDLE;
                result.done_res = 1'b1;
                result.status   = i2cras_pkg::STAT_OK;
              end
              ST_RD_REG: begin
                result.command        = i2cras_pkg::CMD_RX_START;
                result.target_address = saved_device;
                result.read_direction = 1'b1;
                result.load_address   = 1'b1;
                state_next            = ST_RD_FIRST;
              end
              ST_RD_FIRST: begin
                first_rd_next  = item.received_byte;
                result.command = i2cras_pkg::CMD_RX_FINISH;
                state_next     = ST_RD_SECOND;
              end
              default: begin
                result.read_word = {first_rd, item.received_byte};
                state_next       = ST_IDLE;
                result.done_res  = 1'b1;
                result.status    = i2cras_pkg::STAT_OK;
              end
            endcase
          end
        end
      end
      i2cras_pkg::OP_TICK: begin
        // Count down while busy; the last allowed tick ends the transaction.
        if (state != ST_IDLE) begin
          if (ticks_left <= i2cras_pkg::TIMEOUT_W'(1)) begin
            ticks_left_next = '0;
            state_next      = ST_IDLE;
            result.done_res = 1'b1;
            result.status   = i2cras_pkg::STAT_TIMEOUT;
          end else begin
            ticks_left_next = ticks_left - i2cras_pkg::TIMEOUT_W'(1);
          end
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  // State registers, updated only when a request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      saved_device <= '0;
      pending      <= '0;
      first_rd     <= '0;
      ticks_left   <= '0;
    end else if (take) begin
      state        <= state_next;
      saved_device <= saved_device_next;
      pending      <= pending_next;
      first_rd     <= first_rd_next;
      ticks_left   <= ticks_left_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/i2cras_res_buf.sv]
// ----------------------------------------------------------------------------
// I2C register access sequencer result buffer
// Output register with a skid stage, so a request can be taken while a
// result still waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cras_res_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire i2cras_pkg::res_t  push_data,
  output logic                   has_room,
  i2cras_res_if.source           res
);

  logic              out_valid;
  logic              skid_valid;
  i2cras_pkg::res_t  out_data;
  i2cras_pkg::res_t  skid_data;
  logic              pop;

  assign pop       = out_valid && res.ready;
  assign has_room  = !skid_valid;
  assign res.valid = out_valid;
  assign res.data  = out_data;

  // Control: the skid stage fills only when the output register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end
      out_valid <= 1'b1;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end else if (pop && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/i2c_register_access_sequencer_top.sv]
// ----------------------------------------------------------------------------
// I2C register access sequencer
// Turns register read/write requests, controller events and ticks into
// controller commands and completion reports.
// ----------------------------------------------------------------------------
// Results are registered at the output, or in the skid stage while it is
// held. One request per cycle while the buffer has room; the state
// update is one pass of logic. Up to two results are buffered, so ready
// drops only when both are held. Reset (rst, synchronous) returns to
// idle, empties the output and sets the timeout register to 2000000 ticks.
`default_nettype none

module i2c_register_access_sequencer_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [i2cras_pkg::TIMEOUT_W-1:0]  cfg_wdata,
  i2cras_req_if.sink                             req,
  i2cras_res_if.source                           res
);

  logic [i2cras_pkg::TIMEOUT_W-1:0]  timeout_ticks;
  logic                              has_room;
  logic                              take;
  i2cras_pkg::res_t                  step_res;

  assign req.ready = has_room;
  assign take      = req.valid && has_room;

  // Timeout register.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= i2cras_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_wdata;
    end
  end

  i2cras_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (req.data),
    .timeout (timeout_ticks),
    .result  (step_res)
  );

  i2cras_res_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (step_res),
    .has_room  (has_room),
    .res       (res)
  );

  // After a request is taken, the output always holds a valid result in the next cycle.
  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    take |=> res.valid)
    else $error("taken request produced no result");

  // Completion never carries a command.
  a_done_no_cmd: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.done_res |-> res.data.command == i2cras_pkg::CMD_NONE)
    else $error("done reported together with a command");

  // Status code is never the unused value.
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.data.status != 2'd3)
    else $error("illegal status code");

  // Back-pressure only while a result is held at the output.
  a_ready_when_held: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> res.valid)
    else $error("request side stalled with an empty output");

endmodule

`default_nettype wire

[tb/sv/tb_i2c_register_access_sequencer_top.sv]
// ----------------------------------------------------------------------------
// Testbench for the I2C register access sequencer
// Directed request sequences check every controller command, the idle and
// abort cases and the timeout register. Random phases then send mostly
// well-formed transactions with random content, under several idling
// patterns and timeout settings. Every result is checked field by field
// against a cycle-free model of the command sequencer held in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_i2c_register_access_sequencer_top;

  localparam int unsigned CLK_PERIOD       = 20;
  localparam int unsigned RUN_LIMIT_CYCLES = 400000;
  localparam int unsigned MAX_REPORTS      = 50;

  // States of the bench's own sequencer model.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_WR_FIRST,
    SEQ_WR_SECOND,
    SEQ_WR_ONLY,
    SEQ_WR_END,
    SEQ_RD_REG,
    SEQ_RD_FIRST,
    SEQ_RD_SECOND
  } seq_state_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [i2cras_pkg::TIMEOUT_W-1:0] cfg_wdata;

  i2cras_req_if req_ch ();
  i2cras_res_if res_ch ();

  i2c_register_access_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  // Model state, reset values included.
  seq_state_t                       seq_state    = SEQ_IDLE;
  logic [6:0]                       seq_device   = '0;
  logic [15:0]                      seq_wr_bytes = '0;
  logic [7:0]                       seq_rd_high  = '0;
  logic [i2cras_pkg::TIMEOUT_W-1:0] seq_ticks    = '0;
  logic [i2cras_pkg::TIMEOUT_W-1:0] seq_timeout  = i2cras_pkg::TIMEOUT_RESET;

  i2cras_pkg::res_t due_commands[$];
  int unsigned      fail_count         = 0;
  int unsigned      work_done          = 0;
  int unsigned      sender_idle_pct    = 0;
  int unsigned      receiver_stall_pct = 0;

  // Clock generation.
  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Steps the model by one request and returns the command it issues.
  function automatic i2cras_pkg::res_t predict_command(input i2cras_pkg::req_t r);
    i2cras_pkg::res_t o;
    o = '0;
    case (r.opcode) inside
      i2cras_pkg::OP_WRITE_TWO, i2cras_pkg::OP_WRITE_ONE, i2cras_pkg::OP_READ_TWO: begin
        // A new request always starts over, even in the middle of another.
        seq_device   = r.device_address;
        seq_wr_bytes = {r.first_write_byte, r.second_write_byte};
        seq_ticks    = seq_timeout;
        o.target_address = r.device_address;
        o.load_address   = 1'b1;
        o.transmit_byte  = r.register_index;
        o.transmit_valid = 1'b1;
        if (r.opcode == i2cras_pkg::OP_READ_TWO) begin
          o.command = i2cras_pkg::CMD_SINGLE;
          seq_state = SEQ_RD_REG;
        end else begin
          o.command = i2cras_pkg::CMD_START;
          seq_state = (r.opcode == i2cras_pkg::OP_WRITE_TWO) ? SEQ_WR_FIRST : SEQ_WR_ONLY;
        end
      end
      i2cras_pkg::OP_EVENT: begin
        if (seq_state != SEQ_IDLE && r.bus_error) begin
          seq_state  = SEQ_IDLE;
          o.done_res = 1'b1;
          o.status   = i2cras_pkg::STAT_BUS_ERR;
        end else begin
          case (seq_state)
            SEQ_IDLE: ;
            SEQ_WR_FIRST: begin
              o.command        = i2cras_pkg::CMD_CONT;
              o.transmit_byte  = seq_wr_bytes[15:8];
              o.transmit_valid = 1'b1;
              seq_state        = SEQ_WR_SECOND;
            end
            SEQ_WR_SECOND: begin
              o.command        = i2cras_pkg::CMD_FINISH;
              o.transmit_byte  = seq_wr_bytes[7:0];
              o.transmit_valid = 1'b1;
              seq_state        = SEQ_WR_END;
            end
            SEQ_WR_ONLY: begin
              o.command        = i2cras_pkg::CMD_FINISH;
              o.transmit_byte  = seq_wr_bytes[15:8];
              o.transmit_valid = 1'b1;
              seq_state        = SEQ_WR_END;
            end
            SEQ_WR_END: begin
              o.done_res = 1'b1;
              o.status   = i2cras_pkg::STAT_OK;
              seq_state  = SEQ_IDLE;
            end
            SEQ_RD_REG: begin
              o.command        = i2cras_pkg::CMD_RX_START;
              o.target_address = seq_device;
              o.read_direction = 1'b1;
              o.load_address   = 1'b1;
              seq_state        = SEQ_RD_FIRST;
            end
            SEQ_RD_FIRST: begin
              seq_rd_high = r.received_byte;
              o.command   = i2cras_pkg::CMD_RX_FINISH;
              seq_state   = SEQ_RD_SECOND;
            end
            default: begin
              o.read_word = {seq_rd_high, r.received_byte};
              o.done_res  = 1'b1;
              o.status    = i2cras_pkg::STAT_OK;
              seq_state   = SEQ_IDLE;
            end
          endcase
        end
      end
      i2cras_pkg::OP_TICK: begin
        // Ticks only count while a transaction is running.
        if (seq_state != SEQ_IDLE) begin
          if (seq_ticks <= 1) begin
            seq_ticks  = '0;
            seq_state  = SEQ_IDLE;
            o.done_res = 1'b1;
            o.status   = i2cras_pkg::STAT_TIMEOUT;
          end else begin
            seq_ticks = seq_ticks - 1'b1;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic i2cras_pkg::req_t build_item(input logic [2:0] op,
                                                  input logic [6:0] dev,
                                                  input logic [7:0] regnum,
                                                  input logic [7:0] b0,
                                                  input logic [7:0] b1,
                                                  input logic err,
                                                  input logic [7:0] rx);
    i2cras_pkg::req_t r;
    r.opcode            = op;
    r.device_address    = dev;
    r.register_index    = regnum;
    r.first_write_byte  = b0;
    r.second_write_byte = b1;
    r.bus_error         = err;
    r.received_byte     = rx;
    return r;
  endfunction

  function automatic i2cras_pkg::req_t random_item(input logic [2:0] op);
    return build_item(op, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       1'($urandom_range(1)), 8'($urandom));
  endfunction

  // Sends one request, with a random gap first, and records its command.
  task automatic send_request(input i2cras_pkg::req_t r);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    if (r.opcode <= i2cras_pkg::OP_READ_TWO ||
        ((r.opcode == i2cras_pkg::OP_EVENT || r.opcode == i2cras_pkg::OP_TICK) &&
         seq_state != SEQ_IDLE)) begin
      work_done++;
    end
    due_commands.push_back(predict_command(r));
  endtask

  // Holds the request channel idle until every command has come back.
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (due_commands.size() != 0);
  endtask

  task automatic write_timeout_ticks(input logic [i2cras_pkg::TIMEOUT_W-1:0] value);
    wait_for_drain();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    seq_timeout  = value;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endtask

  // Result checking and random receiver stalls.
  always @(posedge clk) begin : result_check
    i2cras_pkg::res_t want;
    i2cras_pkg::res_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (due_commands.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: result with none pending, expected nothing, actual %h",
                   $time, got);
        end
      end else begin
        want = due_commands.pop_front();
        check_field("command", 16'(want.command), 16'(got.command));
        check_field("target_address", 16'(want.target_address),
                    16'(got.target_address));
        check_field("read_direction", 16'(want.read_direction),
                    16'(got.read_direction));
        check_field("load_address", 16'(want.load_address), 16'(got.load_address));
        check_field("transmit_byte", 16'(want.transmit_byte), 16'(got.transmit_byte));
        check_field("transmit_valid", 16'(want.transmit_valid),
                    16'(got.transmit_valid));
        check_field("done_res", 16'(want.done_res), 16'(got.done_res));
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("read_word", want.read_word, got.read_word);
      end
    end
    res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Full two-byte write at the address and byte extremes, with a tick at the
  // reset timeout that must not abort.
  task automatic test_write_two();
    send_request(build_item(i2cras_pkg::OP_WRITE_TWO, 7'h7f, 8'hff, 8'hff, 8'h00,
                            1'b0, 8'h00));
    send_request(build_item(i2cras_pkg::OP_TICK, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b0, 8'h00));
    send_request(build_item(i2cras_pkg::OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b0, 8'hff));
    send_request(build_item(i2cras_pkg::OP_EVENT, 7'h7f, 8'hff, 8'hff, 8'hff,
                            1'b0, 8'h00));
    send_request(build_item(i2cras_pkg::OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b0, 8'h00));
  endtask

  task automatic test_write_one();
    send_request(build_item(i2cras_pkg::OP_WRITE_ONE, 7'h00, 8'h00, 8'h5a, 8'hff,
                            1'b0, 8'h00));
    send_request(build_item(i2cras_pkg::OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b0, 8'h00));
    send_request(build_item(i2cras_pkg::OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b0, 8'h00));
  endtask

  task automatic test_read_two();
    send_request(build_item(i2cras_pkg::OP_READ_TWO, 7'h55, 8'ha5, 8'h00, 8'h00,
                            1'b0, 8'h00));
    send_request(build_item(i2cras_pkg::OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b0, 8'h3c));
    send_request(build_item(i2cras_pkg::OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b0, 8'hff));
    send_request(build_item(i2cras_pkg::OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b0, 8'h00));
  endtask

  // Events, ticks and unused opcodes with nothing running are ignored.
  task automatic test_idle_items();
    send_request(build_item(i2cras_pkg::OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b1, 8'hff));
    send_request(build_item(i2cras_pkg::OP_TICK, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b0, 8'h00));
    send_request(build_item(3'd5, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff));
    send_request(build_item(3'd6, 7'h12, 8'h34, 8'h56, 8'h78, 1'b0, 8'h9a));
    send_request(build_item(3'd7, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff));
  endtask

  // A request in the middle of a write restarts as a read, which a bus error
  // then aborts.
  task automatic test_restart_and_error();
    send_request(build_item(i2cras_pkg::OP_WRITE_TWO, 7'h2a, 8'h11, 8'h22, 8'h33,
                            1'b0, 8'h00));
    send_request(build_item(i2cras_pkg::OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b0, 8'h00));
    send_request(build_item(i2cras_pkg::OP_READ_TWO, 7'h61, 8'h80, 8'h00, 8'h00,
                            1'b0, 8'h00));
    send_request(build_item(i2cras_pkg::OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b0, 8'h00));
    send_request(build_item(i2cras_pkg::OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b1, 8'h77));
  endtask

  // A zero timeout acts as one tick; a timeout of two aborts on the second.
  task automatic test_timeout();
    write_timeout_ticks('0);
    send_request(build_item(i2cras_pkg::OP_WRITE_ONE, 7'h01, 8'h02, 8'h03, 8'h04,
                            1'b0, 8'h00));
    send_request(build_item(i2cras_pkg::OP_TICK, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b0, 8'h00));
    write_timeout_ticks(21'd2);
    send_request(build_item(i2cras_pkg::OP_READ_TWO, 7'h40, 8'h08, 8'h00, 8'h00,
                            1'b0, 8'h00));
    send_request(build_item(i2cras_pkg::OP_TICK, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b0, 8'h00));
    send_request(build_item(i2cras_pkg::OP_TICK, 7'h00, 8'h00, 8'h00, 8'h00,
                            1'b0, 8'h00));
  endtask

  // Random transactions: mostly well-formed sequences with random content,
  // ticks, bus errors and restarts, plus some noise items.
  task automatic test_random_traffic(input int unsigned sender_pct,
                                     input int unsigned stall_pct,
                                     input logic [i2cras_pkg::TIMEOUT_W-1:0] timeout,
                                     input int unsigned items);
    int unsigned      goal;
    int unsigned      n_steps;
    int unsigned      burst;
    logic [2:0]       op;
    i2cras_pkg::req_t r;
    bit               paused;
    write_timeout_ticks(timeout);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = stall_pct;
    goal   = work_done + items;
    paused = 1'b0;
    burst  = (timeout < 12) ? int'(timeout) + 1 : 12;
    while (work_done < goal) begin
      // Halfway through, let the block empty out completely once.
      if (!paused && work_done + items / 2 >= goal) begin
        paused = 1'b1;
        wait_for_drain();
      end
      if ($urandom_range(99) < 8) begin
        send_request(random_item(3'($urandom_range(7))));
      end else begin
        op = 3'($urandom_range(2));
        send_request(random_item(op));
        n_steps = (op == i2cras_pkg::OP_WRITE_ONE) ? 2 : 3;
        for (int k = 0; k < n_steps; k++) begin
          while ($urandom_range(99) < 20) send_request(random_item(i2cras_pkg::OP_TICK));
          if ($urandom_range(99) < 4) begin
            repeat (burst) send_request(random_item(i2cras_pkg::OP_TICK));
          end
          if (seq_state == SEQ_IDLE || $urandom_range(99) < 3) break;
          r = random_item(i2cras_pkg::OP_EVENT);
          r.bus_error = ($urandom_range(99) < 4);
          send_request(r);
        end
      end
    end
  endtask

  // Run limit.
  initial begin
    #(CLK_PERIOD * RUN_LIMIT_CYCLES);
    $display("simulation failed");
    $finish;
  end

  // Test sequence.
  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_write_two();
    test_write_one();
    test_read_two();
    test_idle_items();
    test_restart_and_error();
    test_timeout();

    test_random_traffic(0, 0, i2cras_pkg::TIMEOUT_RESET, 250);
    test_random_traffic(66, 0, 21'd4, 250);
    test_random_traffic(0, 66, 21'd1, 250);
    test_random_traffic(37, 37, 21'h1fffff, 250);
    test_random_traffic(0, 0, 21'd7, 250);
    test_random_traffic(37, 37, 21'd2, 250);

    wait_for_drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
